// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the token scanner modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define CTSC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition must never be seen outside reset
`define CTSC_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== rtl/core/ctsc_pkg.sv =====
// shared types and constants of the c token scanner
// no dependencies
`timescale 1ns / 1ps
package ctsc_pkg;

  localparam int SOURCE_BYTES = 65536;

  // token kinds
  localparam logic [5:0] K_LBRACKET = 6'd0, K_RBRACKET = 6'd1, K_LPAREN = 6'd2,
    K_RPAREN = 6'd3, K_LBRACE = 6'd4, K_RBRACE = 6'd5, K_COMMA = 6'd6, K_SEMI = 6'd7,
    K_DOT = 6'd8, K_ELLIPSIS = 6'd9, K_ANDAND = 6'd10, K_AND_ASSIGN = 6'd11,
    K_AMP = 6'd12, K_OROR = 6'd13, K_OR_ASSIGN = 6'd14, K_PIPE = 6'd15, K_NE = 6'd16,
    K_NOT = 6'd17, K_LE = 6'd18, K_LSHIFT = 6'd19, K_LT = 6'd20, K_GE = 6'd21,
    K_RSHIFT = 6'd22, K_GT = 6'd23, K_EQ = 6'd24, K_ASSIGN = 6'd25, K_INC = 6'd26,
    K_PLUS_ASSIGN = 6'd27, K_PLUS = 6'd28, K_DEC = 6'd29, K_MINUS_ASSIGN = 6'd30,
    K_ARROW = 6'd31, K_MINUS = 6'd32, K_MUL_ASSIGN = 6'd33, K_STAR = 6'd34,
    K_DIV_ASSIGN = 6'd35, K_SLASH = 6'd36, K_MOD_ASSIGN = 6'd37, K_PERCENT = 6'd38,
    K_XOR_ASSIGN = 6'd39, K_CARET = 6'd40, K_TILDE = 6'd41, K_QUESTION = 6'd42,
    K_COLON = 6'd43, K_CONCAT = 6'd44, K_HASH = 6'd45, K_CHAR = 6'd46,
    K_STRING = 6'd47, K_NUMBER = 6'd48, K_IDENT = 6'd49, K_UNKNOWN = 6'd50,
    K_EOF = 6'd51;

  // error codes
  localparam logic [2:0] E_NONE = 3'd0, E_CHAR = 3'd1, E_STRING = 3'd2,
    E_COMMENT = 3'd3, E_QUOTE = 3'd4, E_EXPONENT = 3'd5, E_HEX = 3'd6,
    E_SUFFIX = 3'd7;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [19:0] line;
    logic [31:0] val;
    logic [2:0]  err;
  } tok_t;

  // all results of one input beat
  typedef struct packed {
    logic [1:0]       n;
    tok_t [2:0]       tk;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/core/ctsc_front.sv =====
// front end: accepts source bytes, runs the lexer and forms result bundles
// depends on ctsc_pkg, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ctsc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_ch,
  input  logic              in_end_of_source,
  input  ctsc_pkg::q_stat_t q_stat,
  output logic              push,
  output ctsc_pkg::bundle_t push_data
);
  import ctsc_pkg::*;

  typedef enum logic [4:0] {
    M_IDLE, M_IDENT, M_NZERO, M_NDEC, M_NFRAC, M_EXP0, M_EXPS, M_EXPD,
    M_NOCT, M_HEXD, M_HEXF, M_SUFFIX, M_DOT1, M_DOT2, M_OP, M_LCOMMENT,
    M_BCOMMENT, M_BSTAR, M_STR, M_CHR0, M_CHRE, M_CHRC
  } mode_t;

  localparam logic [2:0] NF_HEX = 3'd1, NF_OCT = 3'd2, NF_FLOAT = 3'd4;
  localparam logic [3:0] SUF_BAD = 4'd8;
  localparam int TAKEN_W = $clog2(SOURCE_BYTES + 1);

  typedef struct packed {
    mode_t       mode;
    logic [15:0] tbeg;
    logic [31:0] acc;
    logic [15:0] held;
    logic        esc;
    logic [3:0]  suf;
    logic [2:0]  nf;
  } lex_st_t;

  typedef struct packed {
    lex_st_t st;
    logic    ev;
    tok_t    tk;
    logic    done;
  } step_t;

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // valid flag and digit value
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (is_digit(c)) return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") begin
      d = c - "a" + 8'd10;
      return {1'b1, d[3:0]};
    end
    if (c >= "A" && c <= "F") begin
      d = c - "A" + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic tok_t mk(logic [5:0] k, logic [15:0] s, logic [15:0] l,
                              logic [31:0] v, logic [2:0] e);
    tok_t t;
    t.kind = k; t.start = s; t.len = l; t.line = 20'd0; t.val = v; t.err = e;
    return t;
  endfunction

  function automatic logic [5:0] op_single(logic [7:0] f);
    case (f)
      "&": return K_AMP;     "|": return K_PIPE;    "!": return K_NOT;
      "<": return K_LT;      ">": return K_GT;      "=": return K_ASSIGN;
      "+": return K_PLUS;    "-": return K_MINUS;   "*": return K_STAR;
      "/": return K_SLASH;   "%": return K_PERCENT; "^": return K_CARET;
      "#": return K_HASH;
      default: return K_UNKNOWN;
    endcase
  endfunction

  // valid flag and kind of a two byte operator
  function automatic logic [6:0] op_pair(logic [7:0] f, logic [7:0] c);
    case (f)
      "&": if (c == "&") return {1'b1, K_ANDAND};
           else if (c == "=") return {1'b1, K_AND_ASSIGN};
      "|": if (c == "|") return {1'b1, K_OROR};
           else if (c == "=") return {1'b1, K_OR_ASSIGN};
      "!": if (c == "=") return {1'b1, K_NE};
      "<": if (c == "=") return {1'b1, K_LE};
           else if (c == "<") return {1'b1, K_LSHIFT};
      ">": if (c == "=") return {1'b1, K_GE};
           else if (c == ">") return {1'b1, K_RSHIFT};
      "=": if (c == "=") return {1'b1, K_EQ};
      "+": if (c == "+") return {1'b1, K_INC};
           else if (c == "=") return {1'b1, K_PLUS_ASSIGN};
      "-": if (c == "-") return {1'b1, K_DEC};
           else if (c == "=") return {1'b1, K_MINUS_ASSIGN};
           else if (c == ">") return {1'b1, K_ARROW};
      "*": if (c == "=") return {1'b1, K_MUL_ASSIGN};
      "/": if (c == "=") return {1'b1, K_DIV_ASSIGN};
      "%": if (c == "=") return {1'b1, K_MOD_ASSIGN};
      "^": if (c == "=") return {1'b1, K_XOR_ASSIGN};
      "#": if (c == "#") return {1'b1, K_CONCAT};
      default: return 7'd0;
    endcase
    return 7'd0;
  endfunction

  // suffix letter automaton, u then l column
  function automatic logic [3:0] suf_next(logic [3:0] s, logic is_l);
    case (s)
      4'd0: return is_l ? 4'd2 : 4'd1;
      4'd1: return is_l ? 4'd3 : SUF_BAD;
      4'd2: return is_l ? 4'd5 : 4'd4;
      4'd3: return is_l ? 4'd6 : SUF_BAD;
      4'd5: return is_l ? SUF_BAD : 4'd7;
      default: return SUF_BAD;
    endcase
  endfunction

  function automatic lex_st_t suffix_add(lex_st_t s, logic [7:0] c);
    lex_st_t r;
    logic [3:0] q;
    r = s;
    q = (s.suf > SUF_BAD) ? SUF_BAD : s.suf;
    if (s.held != 16'hFFFF) r.held = s.held + 16'd1;
    if (c == "u" || c == "U") r.suf = suf_next(q, 1'b0);
    else if (c == "l" || c == "L") r.suf = suf_next(q, 1'b1);
    else r.suf = SUF_BAD;
    return r;
  endfunction

  function automatic lex_st_t begin_tok(mode_t m, logic [15:0] at);
    lex_st_t r;
    r.mode = m; r.tbeg = at; r.acc = 32'd0; r.held = 16'd0;
    r.esc = 1'b0; r.suf = 4'd0; r.nf = 3'd0;
    return r;
  endfunction

  function automatic tok_t finish_tok(lex_st_t s, logic [15:0] pos);
    logic [15:0] l;
    logic flt;
    l = pos - s.tbeg - s.held;
    flt = s.nf[2];
    if (!flt && s.suf >= SUF_BAD) return mk(K_UNKNOWN, s.tbeg, l, 32'd0, E_SUFFIX);
    return mk(K_NUMBER, s.tbeg, l, flt ? 32'd0 : s.acc, E_NONE);
  endfunction

  // one pass of the lexer loop; at most one token per pass
  function automatic step_t lex_step(lex_st_t s, logic [7:0] c, logic [15:0] pos);
    step_t r;
    logic [15:0] tl;
    logic [4:0] hv;
    logic [6:0] pk;
    logic [31:0] d;
    r.st = s; r.ev = 1'b0; r.tk = '0; r.done = 1'b1;
    tl = pos - s.tbeg;
    hv = hex_val(c);
    pk = op_pair(s.acc[7:0], c);
    d = {24'd0, c - "0"};
    unique case (s.mode)
      M_IDENT: begin
        if (!(is_alpha(c) || is_digit(c) || c == "_")) begin
          r.ev = 1'b1; r.tk = mk(K_IDENT, s.tbeg, tl, 32'd0, E_NONE);
          r.st.mode = M_IDLE; r.done = 1'b0;
        end
      end
      M_NZERO: begin
        if (c == "x" || c == "X") begin
          r.st.nf = s.nf | NF_HEX; r.st.tbeg = pos + 16'd1;
          r.st.held = 16'd0; r.st.mode = M_HEXD;
        end else if (is_digit(c)) begin
          r.st.nf = s.nf | NF_OCT; r.st.mode = M_NOCT; r.done = 1'b0;
        end else begin
          r.st.mode = M_NDEC; r.done = 1'b0;
        end
      end
      M_NDEC, M_NFRAC, M_EXPD, M_NOCT, M_HEXD: begin
        if (s.mode == M_NDEC && is_digit(c)) begin
          r.st.acc = (s.acc << 3) + (s.acc << 1) + d;
        end else if (s.mode == M_NDEC && c == ".") begin
          r.st.nf = s.nf | NF_FLOAT; r.st.mode = M_NFRAC;
        end else if (s.mode == M_NDEC && (c == "e" || c == "E")) begin
          r.st.nf = s.nf | NF_FLOAT; r.st.mode = M_EXP0;
        end else if ((s.mode == M_NFRAC || s.mode == M_EXPD) && is_digit(c)) begin
          r.done = 1'b1;
        end else if (s.mode == M_NFRAC && (c == "e" || c == "E")) begin
          r.st.mode = M_EXP0;
        end else if (s.mode == M_NOCT && c >= "0" && c <= "7") begin
          r.st.acc = (s.acc << 3) + d;
        end else if (s.mode == M_HEXD && hv[4]) begin
          r.st.acc = (s.acc << 4) + {28'd0, hv[3:0]}; r.st.held = 16'd1;
        end else if (s.mode == M_HEXD && c == ".") begin
          r.st.nf = s.nf | NF_FLOAT; r.st.held = 16'd0; r.st.mode = M_HEXF;
        end else if (s.mode == M_HEXD && (c == "p" || c == "P")) begin
          r.st.nf = s.nf | NF_FLOAT; r.st.held = 16'd0; r.st.mode = M_EXP0;
        end else if (s.mode == M_HEXD && s.held == 16'd0) begin
          r.ev = 1'b1; r.tk = mk(K_UNKNOWN, s.tbeg, tl, 32'd0, E_HEX);
          r.st.mode = M_IDLE; r.done = 1'b0;
        end else begin
          // end of the number body
          r.st.held = 16'd0;
          if (is_alpha(c)) begin
            r.st.mode = M_SUFFIX;
            r.st = suffix_add(r.st, c);
          end else begin
            r.ev = 1'b1; r.tk = finish_tok(r.st, pos);
            r.st.mode = M_IDLE; r.done = 1'b0;
          end
        end
      end
      M_EXP0, M_EXPS: begin
        if (s.mode == M_EXP0 && (c == "+" || c == "-")) r.st.mode = M_EXPS;
        else if (is_digit(c)) r.st.mode = M_EXPD;
        else begin
          r.ev = 1'b1; r.tk = mk(K_UNKNOWN, s.tbeg, tl, 32'd0, E_EXPONENT);
          r.st.mode = M_IDLE; r.done = 1'b0;
        end
      end
      M_HEXF: begin
        if (hv[4]) r.done = 1'b1;
        else if (c == "p" || c == "P") r.st.mode = M_EXP0;
        else begin
          r.ev = 1'b1; r.tk = mk(K_UNKNOWN, s.tbeg, tl, 32'd0, E_HEX);
          r.st.mode = M_IDLE; r.done = 1'b0;
        end
      end
      M_SUFFIX: begin
        if (is_alpha(c)) r.st = suffix_add(s, c);
        else begin
          r.ev = 1'b1; r.tk = finish_tok(s, pos);
          r.st.mode = M_IDLE; r.done = 1'b0;
        end
      end
      M_DOT1: begin
        if (is_digit(c)) begin
          r.st.nf = NF_FLOAT; r.st.mode = M_NFRAC;
        end else if (c == ".") r.st.mode = M_DOT2;
        else begin
          r.ev = 1'b1; r.tk = mk(K_DOT, s.tbeg, 16'd1, 32'd0, E_NONE);
          r.st.mode = M_IDLE; r.done = 1'b0;
        end
      end
      M_DOT2: begin
        if (c == ".") begin
          r.ev = 1'b1; r.tk = mk(K_ELLIPSIS, s.tbeg, 16'd3, 32'd0, E_NONE);
          r.st.mode = M_IDLE;
        end else begin
          r.ev = 1'b1; r.tk = mk(K_DOT, s.tbeg, 16'd1, 32'd0, E_NONE);
          r.st.tbeg = s.tbeg + 16'd1; r.st.mode = M_DOT1; r.done = 1'b0;
        end
      end
      M_OP: begin
        if (s.acc[7:0] == "/" && c == "/") r.st.mode = M_LCOMMENT;
        else if (s.acc[7:0] == "/" && c == "*") r.st.mode = M_BCOMMENT;
        else if (pk[6]) begin
          r.ev = 1'b1; r.tk = mk(pk[5:0], s.tbeg, 16'd2, 32'd0, E_NONE);
          r.st.mode = M_IDLE;
        end else begin
          r.ev = 1'b1; r.tk = mk(op_single(s.acc[7:0]), s.tbeg, 16'd1, 32'd0, E_NONE);
          r.st.mode = M_IDLE; r.done = 1'b0;
        end
      end
      M_LCOMMENT: if (c == "\n") r.st.mode = M_IDLE;
      M_BCOMMENT: if (c == "*") r.st.mode = M_BSTAR;
      M_BSTAR: begin
        if (c == "/") r.st.mode = M_IDLE;
        else if (c != "*") r.st.mode = M_BCOMMENT;
      end
      M_STR: begin
        if (s.esc) r.st.esc = 1'b0;
        else if (c == "\\") r.st.esc = 1'b1;
        else if (c == "\"") begin
          r.ev = 1'b1; r.tk = mk(K_STRING, s.tbeg, tl, 32'd0, E_NONE);
          r.st.mode = M_IDLE;
        end
      end
      M_CHR0: r.st.mode = (c == "\\") ? M_CHRE : M_CHRC;
      M_CHRE: r.st.mode = M_CHRC;
      M_CHRC: begin
        r.ev = 1'b1;
        if (c == "'") begin
          r.tk = mk(K_CHAR, s.tbeg, tl, 32'd0, E_NONE); r.st.mode = M_IDLE;
        end else begin
          r.tk = mk(K_UNKNOWN, s.tbeg, tl, 32'd0, E_QUOTE);
          r.st.mode = M_IDLE; r.done = 1'b0;
        end
      end
      default: begin
        // between tokens
        r.st.mode = M_IDLE;
        case (c)
          " ", "\t", "\n": r.ev = 1'b0;
          "[": begin r.ev = 1'b1; r.tk = mk(K_LBRACKET, pos, 16'd1, 32'd0, E_NONE); end
          "]": begin r.ev = 1'b1; r.tk = mk(K_RBRACKET, pos, 16'd1, 32'd0, E_NONE); end
          "(": begin r.ev = 1'b1; r.tk = mk(K_LPAREN, pos, 16'd1, 32'd0, E_NONE); end
          ")": begin r.ev = 1'b1; r.tk = mk(K_RPAREN, pos, 16'd1, 32'd0, E_NONE); end
          "{": begin r.ev = 1'b1; r.tk = mk(K_LBRACE, pos, 16'd1, 32'd0, E_NONE); end
          "}": begin r.ev = 1'b1; r.tk = mk(K_RBRACE, pos, 16'd1, 32'd0, E_NONE); end
          ",": begin r.ev = 1'b1; r.tk = mk(K_COMMA, pos, 16'd1, 32'd0, E_NONE); end
          ";": begin r.ev = 1'b1; r.tk = mk(K_SEMI, pos, 16'd1, 32'd0, E_NONE); end
          "~": begin r.ev = 1'b1; r.tk = mk(K_TILDE, pos, 16'd1, 32'd0, E_NONE); end
          "?": begin r.ev = 1'b1; r.tk = mk(K_QUESTION, pos, 16'd1, 32'd0, E_NONE); end
          ":": begin r.ev = 1'b1; r.tk = mk(K_COLON, pos, 16'd1, 32'd0, E_NONE); end
          ".": r.st = begin_tok(M_DOT1, pos);
          "\"": r.st = begin_tok(M_STR, pos + 16'd1);
          "'": r.st = begin_tok(M_CHR0, pos + 16'd1);
          "0": r.st = begin_tok(M_NZERO, pos);
          default: begin
            if (is_digit(c)) begin
              r.st = begin_tok(M_NDEC, pos); r.st.acc = d;
            end else if (is_alpha(c) || c == "_") begin
              r.st = begin_tok(M_IDENT, pos);
            end else if (op_single(c) != K_UNKNOWN) begin
              r.st = begin_tok(M_OP, pos); r.st.acc = {24'd0, c};
            end else begin
              r.ev = 1'b1; r.tk = mk(K_UNKNOWN, pos, 16'd1, 32'd0, E_NONE);
            end
          end
        endcase
      end
    endcase
    return r;
  endfunction

  lex_st_t              st_r, st_nxt;
  logic [15:0]          pos_r, pos_nxt;
  logic [19:0]          line_r, line_nxt;
  logic [TAKEN_W-1:0]   taken_r, taken_nxt;
  logic                 in_acc;
  step_t                ps [4];
  lex_st_t              cur;
  logic                 act;
  logic [1:0]           n;
  tok_t                 slots [3];
  logic [15:0]          ftl, fl;

  assign in_stall = q_stat.full;
  assign in_acc   = in_valid && !in_stall;

  // lexer passes for one byte, or flush on end of source
  always_comb begin
    cur = st_r; act = 1'b1; n = 2'd0;
    for (int j = 0; j < 3; j++) slots[j] = '0;
    st_nxt = st_r; pos_nxt = pos_r; line_nxt = line_r; taken_nxt = taken_r;
    ftl = pos_r - st_r.tbeg;
    fl = pos_r - st_r.tbeg;
    for (int i = 0; i < 4; i++) begin
      ps[i] = lex_step(cur, in_ch, pos_r);
      if (act) begin
        if (ps[i].ev && n != 2'd3) begin
          slots[n] = ps[i].tk;
          n = n + 2'd1;
        end
        cur = ps[i].st;
        act = !ps[i].done;
      end
    end
    if (in_end_of_source) begin
      n = 2'd0;
      case (st_r.mode)
        M_IDENT: begin slots[0] = mk(K_IDENT, st_r.tbeg, ftl, 32'd0, E_NONE); n = 2'd1; end
        M_NZERO, M_NDEC, M_NFRAC, M_EXPD, M_NOCT: begin
          cur = st_r; cur.held = 16'd0; slots[0] = finish_tok(cur, pos_r); n = 2'd1;
        end
        M_SUFFIX: begin slots[0] = finish_tok(st_r, pos_r); n = 2'd1; end
        M_HEXD: begin
          cur = st_r; cur.held = 16'd0; n = 2'd1;
          if (st_r.held == 16'd0) slots[0] = mk(K_UNKNOWN, st_r.tbeg, ftl, 32'd0, E_HEX);
          else slots[0] = finish_tok(cur, pos_r);
        end
        M_HEXF: begin slots[0] = mk(K_UNKNOWN, st_r.tbeg, ftl, 32'd0, E_HEX); n = 2'd1; end
        M_EXP0, M_EXPS: begin
          slots[0] = mk(K_UNKNOWN, st_r.tbeg, ftl, 32'd0, E_EXPONENT); n = 2'd1;
        end
        M_DOT1: begin slots[0] = mk(K_DOT, st_r.tbeg, 16'd1, 32'd0, E_NONE); n = 2'd1; end
        M_DOT2: begin
          slots[0] = mk(K_DOT, st_r.tbeg, 16'd1, 32'd0, E_NONE);
          slots[1] = mk(K_DOT, st_r.tbeg + 16'd1, 16'd1, 32'd0, E_NONE);
          n = 2'd2;
        end
        M_OP: begin
          slots[0] = mk(op_single(st_r.acc[7:0]), st_r.tbeg, 16'd1, 32'd0, E_NONE);
          n = 2'd1;
        end
        M_BCOMMENT, M_BSTAR: begin
          slots[0] = mk(K_UNKNOWN, st_r.tbeg, fl, 32'd0, E_COMMENT); n = 2'd1;
        end
        M_STR: begin slots[0] = mk(K_UNKNOWN, st_r.tbeg, fl, 32'd0, E_STRING); n = 2'd1; end
        M_CHR0, M_CHRE, M_CHRC: begin
          slots[0] = mk(K_UNKNOWN, st_r.tbeg, fl, 32'd0, E_CHAR); n = 2'd1;
        end
        default: n = 2'd0;
      endcase
      slots[n] = mk(K_EOF, pos_r, 16'd0, 32'd0, E_NONE);
      n = n + 2'd1;
      st_nxt = begin_tok(M_IDLE, 16'd0);
      pos_nxt = 16'd0; line_nxt = 20'd1; taken_nxt = '0;
    end else if (taken_r >= TAKEN_W'(SOURCE_BYTES)) begin
      n = 2'd0;
    end else begin
      st_nxt = cur;
      taken_nxt = taken_r + 1'b1;
      pos_nxt = pos_r + 16'd1;
      if (in_ch == "\n" && line_r != 20'hFFFFF) line_nxt = line_r + 20'd1;
    end
  end

  // bundle towards the queue, every token stamped with the current line
  always_comb begin
    push_data.n = n;
    for (int j = 0; j < 3; j++) begin
      push_data.tk[j] = slots[j];
      push_data.tk[j].line = line_r;
    end
  end
  assign push = in_acc && (n != 2'd0);

  // scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= begin_tok(M_IDLE, 16'd0);
      pos_r <= 16'd0;
      line_r <= 20'd1;
      taken_r <= '0;
    end else if (in_acc) begin
      st_r <= st_nxt;
      pos_r <= pos_nxt;
      line_r <= line_nxt;
      taken_r <= taken_nxt;
    end
  end

  `CTSC_ASSERT(a_eof_resets, clk, rst_n, in_acc && in_end_of_source |=> pos_r == 16'd0 && st_r.mode == M_IDLE && line_r == 20'd1, "eof did not reset scanner")
  `CTSC_NEVER(a_eof_bundle_nonempty, clk, rst_n, in_acc && in_end_of_source && !push, "eof beat gave no bundle")

endmodule

// ===== rtl/core/ctsc_queue.sv =====
// two entry bundle queue between front and back ends
// depends on ctsc_pkg, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ctsc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ctsc_pkg::bundle_t push_data,
  input  logic              pop,
  output ctsc_pkg::bundle_t head,
  output ctsc_pkg::q_stat_t q_stat
);
  import ctsc_pkg::*;

  bundle_t    mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign head = mem_r[rp_r];
  assign q_stat.full = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  `CTSC_NEVER(a_no_overflow, clk, rst_n, push && q_stat.full, "push into full queue")
  `CTSC_NEVER(a_no_underflow, clk, rst_n, pop && q_stat.empty, "pop from empty queue")

endmodule

// ===== rtl/core/ctsc_back.sv =====
// back end: delivers the tokens of each queued bundle one beat at a time
// depends on ctsc_pkg, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ctsc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  ctsc_pkg::bundle_t head,
  input  ctsc_pkg::q_stat_t q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [5:0]        out_token_kind,
  output logic [15:0]       out_token_start,
  output logic [15:0]       out_token_length,
  output logic [19:0]       out_line_number,
  output logic [31:0]       out_int_value,
  output logic [2:0]        out_error_code,
  output logic              out_last_result
);
  import ctsc_pkg::*;

  logic [1:0] slot_r;
  tok_t       t;
  logic       last;

  assign out_valid = !q_stat.empty;
  assign t = head.tk[slot_r];
  assign last = (slot_r == head.n - 2'd1);

  assign out_token_kind = t.kind;
  assign out_token_start = t.start;
  assign out_token_length = t.len;
  assign out_line_number = t.line;
  assign out_int_value = t.val;
  assign out_error_code = t.err;
  assign out_last_result = last;
  assign pop = out_valid && !out_stall && last;

  // slot within the head bundle
  always_ff @(posedge clk) begin
    if (!rst_n) slot_r <= 2'd0;
    else if (out_valid && !out_stall) slot_r <= last ? 2'd0 : slot_r + 2'd1;
  end

  `CTSC_ASSERT(a_slot_in_range, clk, rst_n, !q_stat.empty |-> slot_r < head.n, "slot past bundle")

endmodule

// ===== rtl/core/c_token_scanner.sv =====
// top level of the c token scanner: front end, bundle queue, back end
// depends on ctsc_pkg, ctsc_front, ctsc_queue, ctsc_back
//
// channel | direction | beat
// in_     | input     | one source byte or end of source
// out_    | output    | one token record, last_result ends a byte's results
//
// one source byte is taken per cycle; each byte yields zero to three tokens,
// which leave one per cycle from the two entry bundle queue.
// input stalls while the queue is full; output stall backs up into it.
// a byte giving several tokens holds the output until the last of them has left.
// reset is synchronous, active low, and clears scanner state and queue.
`timescale 1ns / 1ps
module c_token_scanner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_end_of_source,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_token_kind,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic [19:0] out_line_number,
  output logic [31:0] out_int_value,
  output logic [2:0]  out_error_code,
  output logic        out_last_result
);
  import ctsc_pkg::*;

  bundle_t push_data, head;
  q_stat_t q_stat;
  logic    push, pop;

  // classify bytes
  ctsc_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_ch, .in_end_of_source,
    .q_stat, .push, .push_data
  );

  // decouple
  ctsc_queue u_queue (
    .clk, .rst_n, .push, .push_data, .pop, .head, .q_stat
  );

  // deliver tokens
  ctsc_back u_back (
    .clk, .rst_n, .head, .q_stat, .pop, .out_valid, .out_stall,
    .out_token_kind, .out_token_start, .out_token_length, .out_line_number,
    .out_int_value, .out_error_code, .out_last_result
  );

endmodule

// ===== verif/tb.sv =====
// self-checking testbench of the c token scanner: source bytes in, token records out
// depends on ctsc_pkg and c_token_scanner; carries its own lexer model for prediction
`timescale 1ns / 1ps
module tb;
  import ctsc_pkg::*;

  localparam int unsigned SUF_BAD = 8;
  localparam int unsigned NF_HEX = 1, NF_OCT = 2, NF_FLOAT = 4;
  localparam int unsigned WATCHDOG_CYCLES = 2000;
  localparam int unsigned RANDOM_ITEMS = 500;

  typedef enum {
    S_IDLE, S_IDENT, S_ZERO, S_DEC, S_FRAC, S_EXP0, S_EXPS, S_EXPD, S_OCT, S_HEXD,
    S_HEXF, S_SUFFIX, S_DOT1, S_DOT2, S_OP, S_LINE, S_BLOCK, S_BSTAR, S_STR, S_CHR0,
    S_CHRE, S_CHRC
  } scan_st_t;

  typedef struct {
    tok_t t;
    bit   last;
  } token_rec_t;

  typedef struct {
    bit [7:0] ch;
    bit       eos;
    bit       typed;
    bit [5:0] kind;
    bit [2:0] err;
  } stim_row_t;

  logic        clk, rst_n;
  logic        in_valid, in_stall, in_end_of_source;
  logic [7:0]  in_ch;
  logic        out_valid, out_stall, out_last_result;
  logic [5:0]  out_token_kind;
  logic [15:0] out_token_start, out_token_length;
  logic [19:0] out_line_number;
  logic [31:0] out_int_value;
  logic [2:0]  out_error_code;

  c_token_scanner i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_ch, .in_end_of_source,
    .out_valid, .out_stall, .out_token_kind, .out_token_start, .out_token_length,
    .out_line_number, .out_int_value, .out_error_code, .out_last_result
  );

  // model state of the lexer
  scan_st_t    mode;
  int unsigned tok_begin, pos, line_cnt, acc, held, esc, suf, nflags, taken;
  token_rec_t  beat_toks[$];
  token_rec_t  expected_toks[$];
  bit [8:0]    src_q[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          sender_quiet = 0;

  // clock
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- lexer model
  function automatic bit is_dig(int unsigned c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alp(int unsigned c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic int hex_digit(int unsigned c);
    if (is_dig(c)) return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic void emit_tok(bit [5:0] k, int unsigned st, int unsigned ln,
                                   int unsigned v, bit [2:0] e);
    token_rec_t r;
    if (beat_toks.size() >= 3) return;
    r.t.kind = k;
    r.t.start = st[15:0];
    r.t.len = ln[15:0];
    r.t.line = line_cnt[19:0];
    r.t.val = v;
    r.t.err = e;
    r.last = 0;
    beat_toks.push_back(r);
  endfunction

  function automatic int unsigned span();
    return (pos - tok_begin) & 16'hffff;
  endfunction

  function automatic void error_tok(bit [2:0] e);
    emit_tok(K_UNKNOWN, tok_begin, span(), 0, e);
    mode = S_IDLE;
  endfunction

  function automatic void open_tok(scan_st_t m, int unsigned at);
    mode = m;
    tok_begin = at & 16'hffff;
    acc = 0;
    held = 0;
    esc = 0;
    suf = 0;
    nflags = 0;
  endfunction

  function automatic void close_number();
    int unsigned ln;
    bit flt;
    ln = (pos - tok_begin - held) & 16'hffff;
    flt = (nflags & NF_FLOAT) != 0;
    if (!flt && suf >= SUF_BAD) emit_tok(K_UNKNOWN, tok_begin, ln, 0, E_SUFFIX);
    else emit_tok(K_NUMBER, tok_begin, ln, flt ? 0 : acc, E_NONE);
    mode = S_IDLE;
  endfunction

  // integer suffix walk: u, l, ul, lu, ll, ull, llu
  function automatic void add_suffix(int unsigned c);
    int unsigned s;
    bit u, l;
    s = suf > SUF_BAD ? SUF_BAD : suf;
    if (held < 16'hffff) held++;
    u = (c == "u" || c == "U");
    l = (c == "l" || c == "L");
    case (s)
      0: suf = u ? 1 : l ? 2 : SUF_BAD;
      1: suf = l ? 3 : SUF_BAD;
      2: suf = u ? 4 : l ? 5 : SUF_BAD;
      3: suf = l ? 6 : SUF_BAD;
      5: suf = u ? 7 : SUF_BAD;
      default: suf = SUF_BAD;
    endcase
  endfunction

  function automatic bit number_tail(int unsigned c);
    held = 0;
    if (is_alp(c)) begin
      mode = S_SUFFIX;
      add_suffix(c);
      return 1;
    end
    close_number();
    return 0;
  endfunction

  function automatic bit [5:0] op_one(int unsigned f);
    case (f)
      "&": return K_AMP;   "|": return K_PIPE;    "!": return K_NOT;
      "<": return K_LT;    ">": return K_GT;      "=": return K_ASSIGN;
      "+": return K_PLUS;  "-": return K_MINUS;   "*": return K_STAR;
      "/": return K_SLASH; "%": return K_PERCENT; "^": return K_CARET;
      "#": return K_HASH;
      default: return K_UNKNOWN;
    endcase
  endfunction

  function automatic int op_two(int unsigned f, int unsigned c);
    case (f)
      "&": return c == "&" ? K_ANDAND : c == "=" ? K_AND_ASSIGN : -1;
      "|": return c == "|" ? K_OROR : c == "=" ? K_OR_ASSIGN : -1;
      "!": return c == "=" ? K_NE : -1;
      "<": return c == "=" ? K_LE : c == "<" ? K_LSHIFT : -1;
      ">": return c == "=" ? K_GE : c == ">" ? K_RSHIFT : -1;
      "=": return c == "=" ? K_EQ : -1;
      "+": return c == "+" ? K_INC : c == "=" ? K_PLUS_ASSIGN : -1;
      "-": return c == "-" ? K_DEC : c == "=" ? K_MINUS_ASSIGN : c == ">" ? K_ARROW : -1;
      "*": return c == "=" ? K_MUL_ASSIGN : -1;
      "/": return c == "=" ? K_DIV_ASSIGN : -1;
      "%": return c == "=" ? K_MOD_ASSIGN : -1;
      "^": return c == "=" ? K_XOR_ASSIGN : -1;
      "#": return c == "#" ? K_CONCAT : -1;
      default: return -1;
    endcase
  endfunction

  function automatic void start_token(int unsigned c);
    case (c)
      " ", "\t", "\n": return;
      "[": begin emit_tok(K_LBRACKET, pos, 1, 0, E_NONE); return; end
      "]": begin emit_tok(K_RBRACKET, pos, 1, 0, E_NONE); return; end
      "(": begin emit_tok(K_LPAREN, pos, 1, 0, E_NONE); return; end
      ")": begin emit_tok(K_RPAREN, pos, 1, 0, E_NONE); return; end
      "{": begin emit_tok(K_LBRACE, pos, 1, 0, E_NONE); return; end
      "}": begin emit_tok(K_RBRACE, pos, 1, 0, E_NONE); return; end
      ",": begin emit_tok(K_COMMA, pos, 1, 0, E_NONE); return; end
      ";": begin emit_tok(K_SEMI, pos, 1, 0, E_NONE); return; end
      "~": begin emit_tok(K_TILDE, pos, 1, 0, E_NONE); return; end
      "?": begin emit_tok(K_QUESTION, pos, 1, 0, E_NONE); return; end
      ":": begin emit_tok(K_COLON, pos, 1, 0, E_NONE); return; end
      ".": begin open_tok(S_DOT1, pos); return; end
      "\"": begin open_tok(S_STR, pos + 1); return; end
      "'": begin open_tok(S_CHR0, pos + 1); return; end
      "0": begin open_tok(S_ZERO, pos); return; end
      default: ;
    endcase
    if (is_dig(c)) begin
      open_tok(S_DEC, pos);
      acc = c - "0";
    end else if (is_alp(c) || c == "_") begin
      open_tok(S_IDENT, pos);
    end else if (op_one(c) != K_UNKNOWN) begin
      open_tok(S_OP, pos);
      acc = c;
    end else begin
      emit_tok(K_UNKNOWN, pos, 1, 0, E_NONE);
    end
  endfunction

  // one byte through the scanner; the byte may be lexed again after a token ends
  function automatic void lex_byte(int unsigned c);
    bit again;
    int k, hv;
    do begin
      again = 0;
      case (mode)
        S_IDENT: begin
          if (!(is_alp(c) || is_dig(c) || c == "_")) begin
            emit_tok(K_IDENT, tok_begin, span(), 0, E_NONE);
            mode = S_IDLE;
            again = 1;
          end
        end
        S_ZERO: begin
          if (c == "x" || c == "X") begin
            nflags |= NF_HEX;
            tok_begin = (pos + 1) & 16'hffff;
            held = 0;
            mode = S_HEXD;
          end else begin
            if (is_dig(c)) begin
              nflags |= NF_OCT;
              mode = S_OCT;
            end else mode = S_DEC;
            again = 1;
          end
        end
        S_DEC: begin
          if (is_dig(c)) acc = acc * 10 + (c - "0");
          else if (c == ".") begin nflags |= NF_FLOAT; mode = S_FRAC; end
          else if (c == "e" || c == "E") begin nflags |= NF_FLOAT; mode = S_EXP0; end
          else again = !number_tail(c);
        end
        S_FRAC: begin
          if (is_dig(c)) ;
          else if (c == "e" || c == "E") mode = S_EXP0;
          else again = !number_tail(c);
        end
        S_EXP0: begin
          if (c == "+" || c == "-") mode = S_EXPS;
          else if (is_dig(c)) mode = S_EXPD;
          else begin error_tok(E_EXPONENT); again = 1; end
        end
        S_EXPS: begin
          if (is_dig(c)) mode = S_EXPD;
          else begin error_tok(E_EXPONENT); again = 1; end
        end
        S_EXPD: begin
          if (!is_dig(c)) again = !number_tail(c);
        end
        S_OCT: begin
          if (c >= "0" && c <= "7") acc = acc * 8 + (c - "0");
          else again = !number_tail(c);
        end
        S_HEXD: begin
          hv = hex_digit(c);
          if (hv >= 0) begin
            acc = acc * 16 + hv;
            held = 1;
          end else if (c == ".") begin
            nflags |= NF_FLOAT; held = 0; mode = S_HEXF;
          end else if (c == "p" || c == "P") begin
            nflags |= NF_FLOAT; held = 0; mode = S_EXP0;
          end else if (held == 0) begin
            error_tok(E_HEX); again = 1;
          end else again = !number_tail(c);
        end
        S_HEXF: begin
          if (hex_digit(c) >= 0) ;
          else if (c == "p" || c == "P") mode = S_EXP0;
          else begin error_tok(E_HEX); again = 1; end
        end
        S_SUFFIX: begin
          if (is_alp(c)) add_suffix(c);
          else begin close_number(); again = 1; end
        end
        S_DOT1: begin
          if (is_dig(c)) begin nflags = NF_FLOAT; mode = S_FRAC; end
          else if (c == ".") mode = S_DOT2;
          else begin
            emit_tok(K_DOT, tok_begin, 1, 0, E_NONE);
            mode = S_IDLE;
            again = 1;
          end
        end
        S_DOT2: begin
          if (c == ".") begin
            emit_tok(K_ELLIPSIS, tok_begin, 3, 0, E_NONE);
            mode = S_IDLE;
          end else begin
            // first dot goes out, the second may still start a float
            emit_tok(K_DOT, tok_begin, 1, 0, E_NONE);
            tok_begin = (tok_begin + 1) & 16'hffff;
            mode = S_DOT1;
            again = 1;
          end
        end
        S_OP: begin
          if (acc == "/" && c == "/") mode = S_LINE;
          else if (acc == "/" && c == "*") mode = S_BLOCK;
          else begin
            k = op_two(acc & 8'hff, c);
            if (k >= 0) begin
              emit_tok(k[5:0], tok_begin, 2, 0, E_NONE);
              mode = S_IDLE;
            end else begin
              emit_tok(op_one(acc & 8'hff), tok_begin, 1, 0, E_NONE);
              mode = S_IDLE;
              again = 1;
            end
          end
        end
        S_LINE: if (c == "\n") mode = S_IDLE;
        S_BLOCK: if (c == "*") mode = S_BSTAR;
        S_BSTAR: begin
          if (c == "/") mode = S_IDLE;
          else if (c != "*") mode = S_BLOCK;
        end
        S_STR: begin
          if (esc) esc = 0;
          else if (c == "\\") esc = 1;
          else if (c == "\"") begin
            emit_tok(K_STRING, tok_begin, span(), 0, E_NONE);
            mode = S_IDLE;
          end
        end
        S_CHR0: mode = (c == "\\") ? S_CHRE : S_CHRC;
        S_CHRE: mode = S_CHRC;
        S_CHRC: begin
          if (c == "'") begin
            emit_tok(K_CHAR, tok_begin, span(), 0, E_NONE);
            mode = S_IDLE;
          end else begin
            error_tok(E_QUOTE);
            again = 1;
          end
        end
        default: begin
          mode = S_IDLE;
          start_token(c);
        end
      endcase
    end while (again);
  endfunction

  // pending token at end of source
  function automatic void flush_pending();
    case (mode)
      S_IDENT: emit_tok(K_IDENT, tok_begin, span(), 0, E_NONE);
      S_ZERO, S_DEC, S_FRAC, S_EXPD, S_OCT: begin held = 0; close_number(); end
      S_SUFFIX: close_number();
      S_HEXD: begin
        if (held == 0) error_tok(E_HEX);
        else begin held = 0; close_number(); end
      end
      S_HEXF: error_tok(E_HEX);
      S_EXP0, S_EXPS: error_tok(E_EXPONENT);
      S_DOT1: emit_tok(K_DOT, tok_begin, 1, 0, E_NONE);
      S_DOT2: begin
        emit_tok(K_DOT, tok_begin, 1, 0, E_NONE);
        emit_tok(K_DOT, tok_begin + 1, 1, 0, E_NONE);
      end
      S_OP: emit_tok(op_one(acc & 8'hff), tok_begin, 1, 0, E_NONE);
      S_BLOCK, S_BSTAR: error_tok(E_COMMENT);
      S_STR: error_tok(E_STRING);
      S_CHR0, S_CHRE, S_CHRC: error_tok(E_CHAR);
      default: ;
    endcase
  endfunction

  function automatic void lexer_reset();
    open_tok(S_IDLE, 0);
    pos = 0;
    line_cnt = 1;
    taken = 0;
  endfunction

  // tokens caused by one accepted beat, left in beat_toks
  function automatic void predict_tokens(bit [7:0] c, bit eos);
    beat_toks.delete();
    if (eos) begin
      flush_pending();
      emit_tok(K_EOF, pos, 0, 0, E_NONE);
      lexer_reset();
    end else if (taken < SOURCE_BYTES) begin
      taken++;
      lex_byte(c);
      if (c == "\n" && line_cnt < 20'hfffff) line_cnt++;
      pos = (pos + 1) & 16'hffff;
    end
    if (beat_toks.size() > 0) beat_toks[beat_toks.size() - 1].last = 1;
  endfunction

  // ---------------------------------------------------------------- sender side
  task automatic send_beat(bit [7:0] c, bit eos, bit typed = 0,
                           bit [5:0] k = K_EOF, bit [2:0] e = E_NONE);
    if (!sender_quiet && $urandom_range(0, 99) < 15) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    in_ch <= c;
    in_end_of_source <= eos;
    do @(posedge clk); while (in_stall);
    predict_tokens(c, eos);
    // typed rows pin the first token of the beat
    if (typed && beat_toks.size() > 0) begin
      beat_toks[0].t.kind = k;
      beat_toks[0].t.err = e;
    end
    foreach (beat_toks[i]) expected_toks.push_back(beat_toks[i]);
  endtask

  task automatic drain_wait();
    in_valid <= 0;
    while (expected_toks.size() != 0) @(posedge clk);
  endtask

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) src_q.push_back({1'b0, s[i]});
  endfunction

  function automatic void push_digits(int unsigned lo, int unsigned hi, int unsigned n);
    for (int i = 0; i < n; i++) src_q.push_back({1'b0, 8'(lo + $urandom_range(0, hi - lo))});
  endfunction

  // random lexeme, mostly well formed
  function automatic void make_fragment();
    string suffixes[10] = '{"", "u", "L", "ul", "LU", "ll", "Ull", "llu", "x", "uu"};
    string ops = "&|!<>=+-*/%^#.~?:[](){},;";
    string hexd = "0123456789abcdefABCDEF";
    string words = "abcxyzQRS_0123456789";
    int sel;
    sel = $urandom_range(0, 12);
    case (sel)
      0: begin
        src_q.push_back({1'b0, $urandom_range(0, 1) ? "_" : 8'("a" + $urandom_range(0, 25))});
        repeat ($urandom_range(0, 5))
          src_q.push_back({1'b0, words[$urandom_range(0, words.len() - 1)]});
      end
      1: begin
        push_digits("1", "9", 1);
        push_digits("0", "9", $urandom_range(0, 11));
        push_text(suffixes[$urandom_range(0, 9)]);
      end
      2: begin
        push_text($urandom_range(0, 1) ? "0x" : "0X");
        repeat ($urandom_range(0, 9)) src_q.push_back({1'b0, hexd[$urandom_range(0, 21)]});
        case ($urandom_range(0, 5))
          0: push_text(".8p+1");
          1: push_text(".f");
          2: push_text("p3");
          default: push_text(suffixes[$urandom_range(0, 9)]);
        endcase
      end
      3: begin
        push_text("0");
        push_digits("0", "9", $urandom_range(0, 6));
        push_text(suffixes[$urandom_range(0, 9)]);
      end
      4: begin
        push_digits("0", "9", $urandom_range(0, 3));
        push_text(".");
        push_digits("0", "9", $urandom_range(0, 3));
        if ($urandom_range(0, 1)) begin
          push_text($urandom_range(0, 1) ? "e" : "E");
          if ($urandom_range(0, 1)) push_text($urandom_range(0, 1) ? "+" : "-");
          push_digits("0", "9", $urandom_range(0, 2));
        end
        if ($urandom_range(0, 1)) push_text("f");
      end
      5: begin
        push_text("\"");
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 4) == 0) push_text($urandom_range(0, 1) ? "\\\"" : "\\n");
          else src_q.push_back({1'b0, 8'($urandom_range(32, 126))});
        end
        if ($urandom_range(0, 7) != 0) push_text("\"");
      end
      6: begin
        push_text("'");
        if ($urandom_range(0, 2) == 0) push_text($urandom_range(0, 1) ? "\\'" : "\\0");
        else src_q.push_back({1'b0, 8'($urandom_range(32, 126))});
        if ($urandom_range(0, 5) != 0) push_text("'");
      end
      7: repeat ($urandom_range(1, 3)) src_q.push_back({1'b0, ops[$urandom_range(0, ops.len() - 1)]});
      8: begin
        if ($urandom_range(0, 1)) push_text("// x*/\n");
        else push_text($urandom_range(0, 1) ? "/* a * b **/" : "/*q*");
      end
      9: src_q.push_back({1'b0, $urandom_range(0, 1) ? " " : "\n"});
      10: src_q.push_back({1'b0, 8'($urandom_range(0, 255))});
      11: src_q.push_back({1'b1, 8'($urandom_range(0, 255))});
      default: push_text("\t");
    endcase
    if ($urandom_range(0, 2) == 0) push_text(" ");
  endfunction

  // directed rows: eof alone, bytes that start nothing, two dots, octal break,
  // bad hex, bad suffix, block comment end, bad closing quote, open string
  stim_row_t directed_rows[] = '{
    '{8'h00, 1, 1, K_EOF, E_NONE},
    '{8'hff, 0, 1, K_UNKNOWN, E_NONE},
    '{8'h0d, 0, 1, K_UNKNOWN, E_NONE},
    '{".", 0, 0, 0, 0}, '{".", 0, 0, 0, 0}, '{"a", 0, 0, 0, 0},
    '{"0", 0, 0, 0, 0}, '{"8", 0, 0, 0, 0}, '{" ", 0, 0, 0, 0},
    '{"0", 0, 0, 0, 0}, '{"x", 0, 0, 0, 0}, '{"g", 0, 1, K_UNKNOWN, E_HEX},
    '{" ", 0, 0, 0, 0},
    '{"1", 0, 0, 0, 0}, '{"u", 0, 0, 0, 0}, '{"q", 0, 0, 0, 0},
    '{" ", 0, 1, K_UNKNOWN, E_SUFFIX},
    '{"/", 0, 0, 0, 0}, '{"*", 0, 0, 0, 0}, '{"*", 0, 0, 0, 0}, '{"/", 0, 0, 0, 0},
    '{"'", 0, 0, 0, 0}, '{"a", 0, 0, 0, 0}, '{"b", 0, 1, K_UNKNOWN, E_QUOTE},
    '{"\"", 0, 0, 0, 0}, '{"\\", 0, 0, 0, 0}, '{"\"", 0, 0, 0, 0},
    '{8'h5a, 1, 1, K_UNKNOWN, E_STRING}
  };

  // stimulus
  initial begin
    int unsigned sent;
    bit [8:0] b;
    rst_n <= 0;
    in_valid <= 0;
    in_ch <= 0;
    in_end_of_source <= 0;
    lexer_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_beat(directed_rows[i].ch, directed_rows[i].eos, directed_rows[i].typed,
                directed_rows[i].kind, directed_rows[i].err);
    drain_wait();

    // random source text
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (src_q.size() == 0) make_fragment();
      b = src_q.pop_front();
      sender_quiet = (sent >= 250 && sent < 350);
      send_beat(b[7:0], b[8]);
      sent++;
    end
    send_beat(8'h00, 1);
    drain_wait();

    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------- receiver side
  initial begin
    int unsigned cyc;
    cyc = 0;
    out_stall <= 0;
    forever begin
      @(posedge clk);
      if (rst_n) cyc++;
      if (cyc == 300) begin
        // long hold-off so the queue fills and the input backs up
        out_stall <= 1;
        repeat (300) @(posedge clk);
        cyc += 300;
      end else begin
        out_stall <= (cyc > 620 && cyc < 800) ? 1'b0 : ($urandom_range(0, 99) < 15);
      end
    end
  end

  // compare one field
  function automatic void check_field(string name, longint unsigned e, longint unsigned a);
    if (e != a) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $realtime, name, e, a);
    end
  endfunction

  // token checker
  always @(posedge clk) begin
    token_rec_t r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_toks.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected token expected none actual kind %0d", $realtime,
                 out_token_kind);
      end else begin
        r = expected_toks.pop_front();
        check_field("kind", r.t.kind, out_token_kind);
        check_field("start", r.t.start, out_token_start);
        check_field("length", r.t.len, out_token_length);
        check_field("line", r.t.line, out_line_number);
        check_field("value", r.t.val, out_int_value);
        check_field("error", r.t.err, out_error_code);
        check_field("last", r.last, out_last_result);
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
